FILE: hw/rtl/vnpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vnpd_pkg;

   localparam int TABLE_BITS     = 12;
   localparam int TABLE_ENTRIES  = 1 << TABLE_BITS;
   localparam int INDEX_BITS     = 24;
   localparam int KEY_BITS       = 2 * INDEX_BITS;
   localparam int COUNT_BITS     = 25;
   localparam int SLOT_BITS      = 12;
   localparam int UCOUNT_BITS    = TABLE_BITS + 1;
   localparam int HASH_BITS      = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int REQ_DATA_BITS  = 48;
   localparam int RSP_DATA_BITS  = 64;

   localparam logic [HASH_BITS-1:0] FNV_BASIS = 32'd2166136261;
   localparam logic [HASH_BITS-1:0] FNV_PRIME = 32'd16777619;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_POSITION_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NORMAL_COUNT   = 2'd1;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      RSP_SRC_PROBE,
      RSP_SRC_HELD,
      RSP_SRC_CLEAR
   } rsp_src_type;

   // Packed MSB first, so is_new lands in bit 0 of the stream word.
   typedef struct packed {
      logic                  table_full;
      logic [SLOT_BITS-1:0]  unique_slot;
      logic                  normal_in_range;
      logic                  vertex_in_range;
      logic [INDEX_BITS-1:0] out_normal_index;
      logic [INDEX_BITS-1:0] out_vertex_index;
      logic                  is_new;
   } rsp_type;

   typedef struct packed {
      logic        load_item;
      logic        hash;
      logic        read;
      logic        advance;
      logic        insert;
      logic        hold_result;
      logic        load_rsp;
      rsp_src_type rsp_src;
      logic        sweep_init;
      logic        sweep_write;
   } cmd_type;

   typedef struct packed {
      logic slot_empty;
      logic key_match;
      logic last_probe;
      logic sweep_last;
   } status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/vertex_normal_pair_dedup_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Deduplicates (vertex index, normal index) corner pairs in a 4096-entry
// open-addressed hash set (FNV-1a home slot, linear probing) held in one
// single-port-write, registered-read memory. Each corner gives one result
// item: is_new with the next unique slot, the echoed indices, the two range
// flags against the configured counts, and table_full when a new pair finds
// no free entry. A corner is hashed to its home slot and then probed, one
// memory read and one compare per probe, until an empty entry, a matching
// key or a search of every entry resolves it; its result is then loaded
// into the output register, or held until that register is free. One item
// is worked on at a time; a finished result waits in the output register
// while the next item is accepted. After reset the block sweeps every
// memory entry before it accepts items; a clear item sweeps it the same
// way and then returns an all-zero result. Configuration writes are taken
// in every cycle.
module vertex_normal_pair_dedup_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [23:0] vertex_index, [47:24] normal_index
   input  wire logic [vnpd_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // [0] kind
   input  wire logic                                 req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [0] is_new, [24:1] out_vertex_index, [48:25] out_normal_index,
   // [49] vertex_in_range, [50] normal_in_range, [62:51] unique_slot,
   // [63] table_full
   output logic [vnpd_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [vnpd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [vnpd_pkg::COUNT_BITS-1:0]      csr_wdata
);
   import vnpd_pkg::*;

   cmd_type    cmd;
   status_type status;
   rsp_type    rsp_data;

   assign csr_ready = 1'b1;

   vnpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   vnpd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .item_vertex_index (req_tdata[INDEX_BITS-1:0]),
      .item_normal_index (req_tdata[KEY_BITS-1:INDEX_BITS]),
      .csr_write         (csr_valid & csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_data          (rsp_data)
   );

   assign rsp_tdata = rsp_data;

endmodule

`default_nettype wire

FILE: hw/rtl/vnpd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module vnpd_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire vnpd_pkg::cmd_type                    cmd,
   output vnpd_pkg::status_type                      status,
   input  wire logic [vnpd_pkg::INDEX_BITS-1:0]      item_vertex_index,
   input  wire logic [vnpd_pkg::INDEX_BITS-1:0]      item_normal_index,
   input  wire logic                                 csr_write,
   input  wire logic [vnpd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [vnpd_pkg::COUNT_BITS-1:0]      csr_wdata,
   output vnpd_pkg::rsp_type                         rsp_data
);
   import vnpd_pkg::*;

   logic [COUNT_BITS-1:0]  position_count_ff;
   logic [COUNT_BITS-1:0]  normal_count_ff;
   logic [INDEX_BITS-1:0]  vi_ff;
   logic [INDEX_BITS-1:0]  ni_ff;
   logic                   vrange_ff;
   logic                   nrange_ff;
   logic [HASH_BITS-1:0]   h1_ff;
   logic [HASH_BITS-1:0]   h1_in;
   logic [HASH_BITS-1:0]   h2_in;
   logic [TABLE_BITS-1:0]  pos_ff;
   logic [TABLE_BITS-1:0]  probe_cnt_ff;
   logic [TABLE_BITS-1:0]  sweep_addr_ff;
   logic [UCOUNT_BITS-1:0] unique_count_ff;
   logic [KEY_BITS:0]      rd_word_ff;
   logic [KEY_BITS-1:0]    key;
   logic                   stored_valid;
   logic                   we;
   logic [TABLE_BITS-1:0]  wr_addr;
   logic [KEY_BITS:0]      wr_word;
   rsp_type                probe_res;
   rsp_type                held_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   // Entry layout: valid bit on top, then normal index, then vertex index.
   logic [KEY_BITS:0] mem [TABLE_ENTRIES];

   always_ff @(posedge clock) begin
      if (reset) begin
         position_count_ff <= '0;
         normal_count_ff   <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_POSITION_COUNT) begin
            position_count_ff <= csr_wdata;
         end
         if (csr_index == CSR_NORMAL_COUNT) begin
            normal_count_ff <= csr_wdata;
         end
      end
   end

   assign h1_in = (FNV_BASIS ^ {{(HASH_BITS-INDEX_BITS){1'b0}}, item_vertex_index}) * FNV_PRIME;
   assign h2_in = (h1_ff ^ {{(HASH_BITS-INDEX_BITS){1'b0}}, ni_ff}) * FNV_PRIME;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         vi_ff     <= item_vertex_index;
         ni_ff     <= item_normal_index;
         vrange_ff <= {1'b0, item_vertex_index} < position_count_ff;
         nrange_ff <= {1'b0, item_normal_index} < normal_count_ff;
         h1_ff     <= h1_in;
      end
      if (cmd.hash) begin
         pos_ff       <= h2_in[TABLE_BITS-1:0];
         probe_cnt_ff <= '0;
      end else if (cmd.advance) begin
         // Linear probe, wrapping at the table end.
         pos_ff       <= pos_ff + 1'b1;
         probe_cnt_ff <= probe_cnt_ff + 1'b1;
      end
      if (cmd.read) begin
         rd_word_ff <= mem[pos_ff];
      end
      if (cmd.hold_result) begin
         held_ff <= probe_res;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_addr_ff   <= '0;
         unique_count_ff <= '0;
      end else begin
         if (cmd.sweep_init) begin
            sweep_addr_ff   <= '0;
            unique_count_ff <= '0;
         end else begin
            if (cmd.sweep_write) begin
               sweep_addr_ff <= sweep_addr_ff + 1'b1;
            end
            if (cmd.insert) begin
               unique_count_ff <= unique_count_ff + 1'b1;
            end
         end
      end
   end

   assign key     = {ni_ff, vi_ff};
   assign we      = cmd.sweep_write | cmd.insert;
   assign wr_addr = cmd.sweep_write ? sweep_addr_ff : pos_ff;
   assign wr_word = cmd.sweep_write ? '0 : {1'b1, key};

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_word;
      end
   end

   assign stored_valid      = rd_word_ff[KEY_BITS];
   assign status.slot_empty = !stored_valid;
   assign status.key_match  = stored_valid && (rd_word_ff[KEY_BITS-1:0] == key);
   assign status.last_probe = probe_cnt_ff == TABLE_BITS'(TABLE_ENTRIES - 1);
   assign status.sweep_last = sweep_addr_ff == TABLE_BITS'(TABLE_ENTRIES - 1);

   always_comb begin
      probe_res.is_new           = status.slot_empty;
      probe_res.out_vertex_index = vi_ff;
      probe_res.out_normal_index = ni_ff;
      probe_res.vertex_in_range  = vrange_ff;
      probe_res.normal_in_range  = nrange_ff;
      probe_res.unique_slot      = status.slot_empty ?
                                   unique_count_ff[SLOT_BITS-1:0] : '0;
      probe_res.table_full       = !status.slot_empty && !status.key_match &&
                                   status.last_probe;
   end

   always_comb begin
      case (cmd.rsp_src)
         RSP_SRC_PROBE: rsp_in = probe_res;
         RSP_SRC_HELD:  rsp_in = held_ff;
         default:       rsp_in = '0;
      endcase
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/vnpd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module vnpd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic                  req_kind,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire vnpd_pkg::status_type  status,
   output vnpd_pkg::cmd_type          cmd
);
   import vnpd_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      clear_pending_ff;
   logic      clear_pending_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_free;
   logic      probe_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_SWEEP;
         clear_pending_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clear_pending_ff <= clear_pending_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign probe_done = status.slot_empty || status.key_match || status.last_probe;

   always_comb begin
      state_in         = state_ff;
      clear_pending_in = clear_pending_ff;
      cmd              = '0;
      cmd.rsp_src      = RSP_SRC_PROBE;
      req_tready       = 1'b0;

      unique case (state_ff)
         ST_SWEEP: begin
            cmd.sweep_write = 1'b1;
            if (status.sweep_last) begin
               state_in = clear_pending_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_kind) begin
                  cmd.sweep_init   = 1'b1;
                  clear_pending_in = 1'b1;
                  state_in         = ST_SWEEP;
               end else begin
                  cmd.load_item    = 1'b1;
                  clear_pending_in = 1'b0;
                  state_in         = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            cmd.hash = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (probe_done) begin
               cmd.insert      = status.slot_empty;
               cmd.hold_result = 1'b1;
               if (rsp_free) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_DONE: begin
            cmd.rsp_src = clear_pending_ff ? RSP_SRC_CLEAR : RSP_SRC_HELD;
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: sim/vertex_normal_pair_dedup_core_test.sv
`timescale 1ns / 1ps

module vertex_normal_pair_dedup_core_test;
   import vnpd_pkg::*;

   localparam bit KIND_CORNER = 1'b0;
   localparam bit KIND_CLEAR  = 1'b1;

   // indexes that map to no register; writes to them must change nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HIGH = 2'd3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 25'd16777216;

   // filling the whole table dominates the run; the limit leaves a wide
   // margin above the time that it takes
   localparam int CYCLE_LIMIT = 4_000_000;

   class corner_dedup_board;
      logic [KEY_BITS-1:0]    stored_key [TABLE_ENTRIES];
      bit                     occupied [TABLE_ENTRIES];
      logic [UCOUNT_BITS-1:0] pair_total;
      logic [COUNT_BITS-1:0]  position_limit;
      logic [COUNT_BITS-1:0]  normal_limit;
      rsp_type                awaited [$];
      int unsigned            faults;

      function new();
         foreach (occupied[i]) occupied[i] = 1'b0;
         pair_total     = '0;
         position_limit = '0;
         normal_limit   = '0;
         faults         = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] idx,
                                   logic [COUNT_BITS-1:0] value);
         case (idx)
            CSR_POSITION_COUNT: position_limit = value;
            CSR_NORMAL_COUNT:   normal_limit = value;
            default: ;
         endcase
      endfunction

      // FNV-1a over the two indices, folded to the table size
      function logic [TABLE_BITS-1:0] home_slot(logic [INDEX_BITS-1:0] vi,
                                                logic [INDEX_BITS-1:0] ni);
         logic [HASH_BITS-1:0] h;
         h = FNV_BASIS;
         h = h ^ HASH_BITS'(vi);
         h = h * FNV_PRIME;
         h = h ^ HASH_BITS'(ni);
         h = h * FNV_PRIME;
         return h[TABLE_BITS-1:0];
      endfunction

      function void note_corner(bit clear, logic [INDEX_BITS-1:0] vi,
                                logic [INDEX_BITS-1:0] ni);
         rsp_type                exp;
         logic [KEY_BITS-1:0]    key;
         logic [TABLE_BITS-1:0]  pos;
         logic [UCOUNT_BITS-1:0] slot;
         bit                     found;
         bit                     inserted;
         exp      = '0;
         found    = 1'b0;
         inserted = 1'b0;
         slot     = '0;
         if (clear) begin
            foreach (occupied[i]) occupied[i] = 1'b0;
            pair_total = '0;
            awaited.push_back(exp);
            return;
         end
         key = {ni, vi};
         pos = home_slot(vi, ni);
         // linear probe; the position wraps at the table size on its own
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!occupied[pos]) begin
               occupied[pos]   = 1'b1;
               stored_key[pos] = key;
               slot            = pair_total;
               pair_total      = pair_total + 1'b1;
               inserted        = 1'b1;
               break;
            end
            if (stored_key[pos] == key) begin
               found = 1'b1;
               break;
            end
            pos = pos + 1'b1;
         end
         exp.is_new           = inserted;
         exp.out_vertex_index = vi;
         exp.out_normal_index = ni;
         exp.vertex_in_range  = COUNT_BITS'(vi) < position_limit;
         exp.normal_in_range  = COUNT_BITS'(ni) < normal_limit;
         exp.unique_slot      = inserted ? slot[SLOT_BITS-1:0] : '0;
         exp.table_full       = !inserted && !found;
         awaited.push_back(exp);
      endfunction

      function void compare_field(string name, logic [63:0] exp, logic [63:0] got);
         if (exp !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, exp, got);
            faults++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %0h", $time, got);
            faults++;
            return;
         end
         exp = awaited.pop_front();
         compare_field("is_new", 64'(exp.is_new), 64'(got.is_new));
         compare_field("out_vertex_index", 64'(exp.out_vertex_index),
                       64'(got.out_vertex_index));
         compare_field("out_normal_index", 64'(exp.out_normal_index),
                       64'(got.out_normal_index));
         compare_field("vertex_in_range", 64'(exp.vertex_in_range),
                       64'(got.vertex_in_range));
         compare_field("normal_in_range", 64'(exp.normal_in_range),
                       64'(got.normal_in_range));
         compare_field("unique_slot", 64'(exp.unique_slot), 64'(got.unique_slot));
         compare_field("table_full", 64'(exp.table_full), 64'(got.table_full));
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;

   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_DATA_BITS-1:0]    req_tdata  = '0;
   logic                        req_tuser  = KIND_CORNER;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]    rsp_tdata;
   logic                        csr_valid  = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index  = CSR_POSITION_COUNT;
   logic [COUNT_BITS-1:0]       csr_wdata  = '0;

   corner_dedup_board board;
   bit                steady = 1'b0;
   int unsigned       cycles = 0;
   logic [KEY_BITS-1:0] recent_pairs [$];

   vertex_normal_pair_dedup_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit take_break();
      return !steady && ($urandom_range(99) < 18);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("vertex_normal_pair_dedup_core: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_type'(rsp_tdata));
      rsp_tready <= !take_break();
   end

   task automatic send_item(bit kind, logic [INDEX_BITS-1:0] vi,
                            logic [INDEX_BITS-1:0] ni);
      if (take_break()) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (take_break());
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {ni, vi};
      do @(posedge clock); while (!req_tready);
      board.note_corner(kind == KIND_CLEAR, vi, ni);
   endtask

   task automatic send_corner(logic [INDEX_BITS-1:0] vi, logic [INDEX_BITS-1:0] ni);
      send_item(KIND_CORNER, vi, ni);
   endtask

   // hold off the sender until every outstanding item has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.awaited.size() != 0);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [COUNT_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_register(idx, value);
   endtask

   task automatic set_counts(logic [COUNT_BITS-1:0] pc, logic [COUNT_BITS-1:0] nc,
                             bit poke_spare);
      if (poke_spare) begin
         write_csr(CSR_SPARE_LOW, 25'($urandom));
         write_csr(CSR_SPARE_HIGH, 25'($urandom));
      end
      write_csr(CSR_POSITION_COUNT, pc);
      write_csr(CSR_NORMAL_COUNT, nc);
      csr_valid <= 1'b0;
   endtask

   // find two normal indices that share the given home slot with vertex vi
   function automatic void pick_colliders(input logic [INDEX_BITS-1:0] vi,
                                          input logic [TABLE_BITS-1:0] target,
                                          input logic [INDEX_BITS-1:0] start,
                                          output logic [INDEX_BITS-1:0] first,
                                          output logic [INDEX_BITS-1:0] second);
      logic [INDEX_BITS-1:0] cand;
      int                    hits;
      cand   = start;
      hits   = 0;
      first  = '0;
      second = '0;
      while (hits < 2) begin
         if (board.home_slot(vi, cand) == target) begin
            if (hits == 0) first = cand;
            else second = cand;
            hits++;
         end
         cand = cand + 1'b1;
      end
   endfunction

   task automatic random_corners(int count);
      logic [INDEX_BITS-1:0] vi;
      logic [INDEX_BITS-1:0] ni;
      logic [KEY_BITS-1:0]   pair;
      int                    pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            send_item(KIND_CLEAR, 24'($urandom), 24'($urandom));
            continue;
         end
         if (pick < 40 && recent_pairs.size() != 0) begin
            pair = recent_pairs[$urandom_range(recent_pairs.size() - 1)];
            vi   = pair[INDEX_BITS-1:0];
            ni   = pair[KEY_BITS-1:INDEX_BITS];
         end else if (pick < 70) begin
            vi = 24'($urandom_range(2047));
            ni = 24'($urandom_range(2047));
         end else begin
            vi = 24'($urandom);
            ni = 24'($urandom);
         end
         send_corner(vi, ni);
         recent_pairs.push_back({ni, vi});
         if (recent_pairs.size() > 64) void'(recent_pairs.pop_front());
      end
   endtask

   initial begin
      logic [INDEX_BITS-1:0] near_a, near_b, wrap_a, wrap_b;
      logic [KEY_BITS-1:0]   fill_keys [$];
      logic [KEY_BITS-1:0]   pair;
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero counts: nothing is in range
      set_counts('0, '0, 1'b1);
      send_corner(24'h000000, 24'h000000);
      send_corner(24'h000000, 24'h000000);
      send_corner(24'hFFFFFF, 24'hFFFFFF);
      drain();

      set_counts(25'd1000, 25'h0800000, 1'b0);
      send_corner(24'd999, 24'h7FFFFF);
      send_corner(24'd1000, 24'h800000);
      send_corner(24'hFFFFFF, 24'h000000);
      send_corner(24'h000000, 24'hFFFFFF);
      send_corner(24'h555555, 24'hAAAAAA);
      send_corner(24'hAAAAAA, 24'h555555);
      // pairs that collide on one home slot force probing past occupied entries
      pick_colliders(24'd5, board.home_slot(24'd5, 24'd7), 24'd8, near_a, near_b);
      send_corner(24'd5, 24'd7);
      send_corner(24'd5, near_a);
      send_corner(24'd5, near_b);
      send_corner(24'd5, near_b);
      send_corner(24'd5, 24'd7);
      // collisions on the last entry wrap the probe to the table start
      pick_colliders(24'd9, '1, 24'd0, wrap_a, wrap_b);
      send_corner(24'd9, wrap_a);
      send_corner(24'd9, wrap_b);
      send_corner(24'd9, wrap_b);
      send_item(KIND_CLEAR, 24'($urandom), 24'($urandom));
      send_corner(24'h000000, 24'h000000);
      send_corner(24'hFFFFFF, 24'hFFFFFF);
      send_corner(24'd5, 24'd7);
      drain();

      set_counts(COUNT_MAX, COUNT_MAX, 1'b0);
      steady = 1'b1;
      random_corners(120);
      steady = 1'b0;
      random_corners(100);
      drain();

      set_counts(25'($urandom_range(1, 2048)), 25'($urandom_range(1, 2048)), 1'b0);
      random_corners(230);
      drain();

      // fill every entry, then ask for new and stored pairs on a full table
      set_counts(25'd1, COUNT_MAX, 1'b0);
      send_item(KIND_CLEAR, 24'($urandom), 24'($urandom));
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         pair = {1'b0, 23'($urandom), 12'($urandom), 12'(i)};
         fill_keys.push_back(pair);
         send_corner(pair[INDEX_BITS-1:0], pair[KEY_BITS-1:INDEX_BITS]);
      end
      for (int i = 0; i < 4; i++) begin
         send_corner(24'($urandom), {1'b1, 23'($urandom)});
         pair = fill_keys[$urandom_range(TABLE_ENTRIES - 1)];
         send_corner(pair[INDEX_BITS-1:0], pair[KEY_BITS-1:INDEX_BITS]);
      end
      send_item(KIND_CLEAR, 24'($urandom), 24'($urandom));
      send_corner(fill_keys[0][INDEX_BITS-1:0], fill_keys[0][KEY_BITS-1:INDEX_BITS]);
      drain();

      set_counts(25'd16777215, 25'd16777215, 1'b0);
      send_corner(24'hFFFFFF, 24'hFFFFFE);
      send_corner(24'hFFFFFE, 24'hFFFFFF);
      random_corners(200);

      drain();
      repeat (20) @(posedge clock);
      if (board.faults == 0)
         $display("vertex_normal_pair_dedup_core: match");
      else
         $display("vertex_normal_pair_dedup_core: mismatch");
      $finish;
   end

endmodule
